FILE: rtl/core/mhus_pkg.sv
`timescale 1ns / 1ps
package mhus_pkg;
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  typedef logic [31:0] word_t;
endpackage

FILE: rtl/core/mhus_request_if.sv
`timescale 1ns / 1ps
interface mhus_request_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic signed [31:0] key_value;
  logic [7:0]  read_index;
  modport source (output valid, opcode, key_value, read_index, input ready);
  modport sink (input valid, opcode, key_value, read_index, output ready);
endinterface

FILE: rtl/core/mhus_response_if.sv
`timescale 1ns / 1ps
interface mhus_response_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] read_data;
  logic [8:0]  element_count;
  logic signed [31:0] top_value;
  modport source (output valid, status, read_data, element_count, top_value, input ready);
  modport sink (input valid, status, read_data, element_count, top_value, output ready);
endinterface

FILE: rtl/core/max_heap_unique_set.sv
`timescale 1ns / 1ps
// Set of distinct signed 32-bit values held as a binary max-heap in one
// simple dual-port RAM (one write, one registered read per cycle).
// request: one beat carries opcode, key_value and read_index.
// response: one beat per request with status, read_data, element_count and
// the current root (top_value).
// Request steps: clear resets the fill count; read fetches one slot;
//   insert runs a duplicate scan, then a sift-up;
//   remove runs a scan and an in-place compaction, then rebuilds the heap
//   by sifting up each remaining element; the single RAM read port
//   paces every loop.
// One request is in flight at a time; request.ready is high while the
// sequencer is idle, so a new beat may be taken while a response waits.
// A stalled response holds its beat and the next finished result waits for
// it. Reset empties the set at once (fill count to zero, no clearing pass);
// RAM contents are only used below the fill count.
module max_heap_unique_set (
  input logic            clk,
  input logic            rst,
  mhus_request_if.sink   request,
  mhus_response_if.source response
);
  import mhus_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_SIFT_RD  = 4'd2;
  localparam logic [3:0] S_SIFT_CMP = 4'd3;
  localparam logic [3:0] S_COMP     = 4'd4;
  localparam logic [3:0] S_RB_RD    = 4'd5;
  localparam logic [3:0] S_RB_LD    = 4'd6;
  localparam logic [3:0] S_RD_WAIT  = 4'd7;
  localparam logic [3:0] S_TOP_RD   = 4'd8;
  localparam logic [3:0] S_TOP_CAP  = 4'd9;

  word_t mem [CAPACITY];
  word_t rdata;

  logic [3:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] ra, ra_next;
  logic [CW-1:0] wc, wc_next;
  logic [CW-1:0] idx, idx_next;
  logic [AW-1:0] pos, pos_next;
  logic          pend, pend_next;
  logic          found, found_next;
  logic          rebuild, rebuild_next;
  logic [1:0]    op, op_next;
  word_t         key, key_next;
  word_t         val, val_next;
  logic [2:0]    stat, stat_next;
  word_t         data, data_next;
  logic          ovalid, ovalid_next;
  logic [2:0]    o_status, o_status_next;
  word_t         o_data, o_data_next;
  logic [CW-1:0] o_count, o_count_next;
  word_t         o_top, o_top_next;

  logic          we;
  logic [AW-1:0] wa;
  word_t         wd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] parent;
  logic          hit;
  logic          sift_done;

  assign request.ready          = (state == S_IDLE);
  assign response.valid         = ovalid;
  assign response.status        = o_status;
  assign response.read_data     = o_data;
  assign response.element_count = 9'(o_count);
  assign response.top_value     = o_top;

  assign parent = (pos - AW'(1)) >> 1;
  assign hit    = pend && (rdata == key);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    ra_next       = ra;
    wc_next       = wc;
    idx_next      = idx;
    pos_next      = pos;
    pend_next     = 1'b0;
    found_next    = found;
    rebuild_next  = rebuild;
    op_next       = op;
    key_next      = key;
    val_next      = val;
    stat_next     = stat;
    data_next     = data;
    ovalid_next   = ovalid && !response.ready;
    o_status_next = o_status;
    o_data_next   = o_data;
    o_count_next  = o_count;
    o_top_next    = o_top;
    we            = 1'b0;
    wa            = pos;
    wd            = val;
    rd_addr       = '0;
    sift_done     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (request.valid) begin
          op_next     = request.opcode;
          key_next    = request.key_value;
          data_next   = '0;
          stat_next   = ST_OK;
          ra_next     = '0;
          found_next  = 1'b0;
          unique case (request.opcode)
            OP_INSERT, OP_REMOVE: state_next = S_SCAN;
            OP_CLEAR: begin
              cnt_next   = '0;
              state_next = S_TOP_RD;
            end
            OP_READ: begin
              if (32'(request.read_index) < 32'(cnt)) begin
                rd_addr    = AW'(request.read_index);
                state_next = S_RD_WAIT;
              end else begin
                stat_next  = ST_RANGE;
                state_next = S_TOP_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        found_next = found || hit;
        if (ra < cnt) begin
          rd_addr   = ra[AW-1:0];
          ra_next   = ra + CW'(1);
          pend_next = 1'b1;
        end else if (!pend) begin
          if (op == OP_INSERT) begin
            if (found) begin
              stat_next  = ST_DUP;
              state_next = S_TOP_RD;
            end else if (32'(cnt) == CAPACITY) begin
              stat_next  = ST_FULL;
              state_next = S_TOP_RD;
            end else begin
              pos_next     = cnt[AW-1:0];
              val_next     = key;
              cnt_next     = cnt + CW'(1);
              rebuild_next = 1'b0;
              state_next   = S_SIFT_RD;
            end
          end else if (!found) begin
            stat_next  = ST_MISSING;
            state_next = S_TOP_RD;
          end else begin
            ra_next    = '0;
            wc_next    = '0;
            state_next = S_COMP;
          end
        end
      end
      S_COMP: begin
        // in-place compaction: write slot never passes the read slot
        if (pend && rdata != key) begin
          we      = 1'b1;
          wa      = wc[AW-1:0];
          wd      = rdata;
          wc_next = wc + CW'(1);
        end
        if (ra < cnt) begin
          rd_addr   = ra[AW-1:0];
          ra_next   = ra + CW'(1);
          pend_next = 1'b1;
        end else if (!pend) begin
          cnt_next     = wc;
          rebuild_next = 1'b1;
          idx_next     = CW'(1);
          state_next   = (wc > CW'(1)) ? S_RB_RD : S_TOP_RD;
        end
      end
      S_RB_RD: begin
        rd_addr    = idx[AW-1:0];
        state_next = S_RB_LD;
      end
      S_RB_LD: begin
        val_next   = rdata;
        pos_next   = idx[AW-1:0];
        state_next = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        if (pos == '0) begin
          we        = 1'b1;
          sift_done = 1'b1;
        end else begin
          rd_addr    = parent;
          state_next = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        we = 1'b1;
        if ($signed(rdata) < $signed(val)) begin
          wd         = rdata;
          pos_next   = parent;
          state_next = S_SIFT_RD;
        end else begin
          sift_done = 1'b1;
        end
      end
      S_RD_WAIT: begin
        data_next  = rdata;
        state_next = S_TOP_RD;
      end
      S_TOP_RD: begin
        state_next = S_TOP_CAP;
      end
      S_TOP_CAP: begin
        if (!ovalid || response.ready) begin
          ovalid_next   = 1'b1;
          o_status_next = stat;
          o_data_next   = data;
          o_count_next  = cnt;
          o_top_next    = (cnt != '0) ? rdata : '0;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (sift_done) begin
      if (rebuild && (idx + CW'(1)) < cnt) begin
        idx_next   = idx + CW'(1);
        state_next = S_RB_RD;
      end else begin
        state_next = S_TOP_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      ovalid  <= 1'b0;
      pend    <= 1'b0;
      found   <= 1'b0;
      rebuild <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      ovalid  <= ovalid_next;
      pend    <= pend_next;
      found   <= found_next;
      rebuild <= rebuild_next;
    end
    ra       <= ra_next;
    wc       <= wc_next;
    idx      <= idx_next;
    pos      <= pos_next;
    op       <= op_next;
    key      <= key_next;
    val      <= val_next;
    stat     <= stat_next;
    data     <= data_next;
    o_status <= o_status_next;
    o_data   <= o_data_next;
    o_count  <= o_count_next;
    o_top    <= o_top_next;
  end

  assert property (@(posedge clk) disable iff (rst) 32'(cnt) <= CAPACITY)
    else $error("fill count beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> state != S_IDLE)
    else $error("accepted beat left sequencer idle");
  assert property (@(posedge clk) disable iff (rst)
    state == S_SIFT_CMP |-> $past(state) == S_SIFT_RD)
    else $error("sift compare without parent read");
  assert property (@(posedge clk) disable iff (rst)
    state == S_COMP |-> wc <= ra)
    else $error("compaction write overtook read");
endmodule

FILE: tb/mhus_tb_if.sv
`timescale 1ns / 1ps
// The channel interfaces are part of the RTL; this file only groups the
// per-beat types that the testbench uses.
package mhus_tb_pkg;
  import mhus_pkg::*;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key_value;
    logic [7:0]  read_index;
  } heap_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [8:0]  element_count;
    logic [31:0] top_value;
  } heap_rsp_t;
endpackage

FILE: tb/max_heap_unique_set_tb.sv
`timescale 1ns / 1ps
module max_heap_unique_set_tb;
  import mhus_pkg::*;
  import mhus_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mhus_request_if  request ();
  mhus_response_if response ();

  max_heap_unique_set DUT (
    .clk      (clk),
    .rst      (rst),
    .request  (request.sink),
    .response (response.source)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [31:0] heap_img [CAPACITY];
  int unsigned heap_fill;
  heap_rsp_t   rsp_pending [$];
  heap_rsp_t   rsp_typed [$];
  logic        rsp_has_typed [$];
  int unsigned mismatches;
  bit          quiet_rx;
  bit          hold_rx;

  function automatic bit heap_holds(logic [31:0] v);
    for (int i = 0; i < heap_fill; i++)
      if (heap_img[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [2:0] heap_put(logic [31:0] v);
    int unsigned pos;
    int unsigned up;
    logic [31:0] t;
    if (heap_holds(v)) return ST_DUP;
    if (heap_fill >= CAPACITY) return ST_FULL;
    pos = heap_fill;
    heap_img[pos] = v;
    heap_fill++;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if ($signed(heap_img[up]) < $signed(heap_img[pos])) begin
        t = heap_img[up];
        heap_img[up] = heap_img[pos];
        heap_img[pos] = t;
        pos = up;
      end else break;
    end
    return ST_OK;
  endfunction

  function automatic heap_rsp_t heap_apply(heap_cmd_t c);
    heap_rsp_t r;
    logic [31:0] keep [$];
    r = '0;
    case (c.opcode)
      OP_INSERT: r.status = heap_put(c.key_value);
      OP_REMOVE: begin
        if (heap_fill == 0 || !heap_holds(c.key_value)) r.status = ST_MISSING;
        else begin
          for (int i = 0; i < heap_fill; i++)
            if (heap_img[i] != c.key_value) keep.push_back(heap_img[i]);
          heap_fill = 0;
          foreach (keep[i]) void'(heap_put(keep[i]));
          r.status = ST_OK;
        end
      end
      OP_CLEAR: begin
        heap_fill = 0;
        r.status = ST_OK;
      end
      default: begin
        if (c.read_index < heap_fill) begin
          r.read_data = heap_img[c.read_index];
          r.status = ST_OK;
        end else r.status = ST_RANGE;
      end
    endcase
    r.element_count = heap_fill[8:0];
    r.top_value = heap_fill > 0 ? heap_img[0] : '0;
    return r;
  endfunction

  // random values, biased toward a small pool so that duplicates and
  // removes of present values are common
  logic [31:0] key_pool [16];

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return key_pool[$urandom_range(0, 15)];
      6: return heap_fill > 0 ? heap_img[$urandom_range(0, heap_fill - 1)] : $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(heap_cmd_t c, bit idle_ok, bit typed = 1'b0,
                          heap_rsp_t want = '0);
    heap_rsp_t p;
    if (idle_ok) begin
      while ($urandom_range(0, 99) < 11) begin
        request.valid <= 1'b0;
        @(posedge clk);
      end
    end
    request.valid      <= 1'b1;
    request.opcode     <= c.opcode;
    request.key_value  <= c.key_value;
    request.read_index <= c.read_index;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    p = heap_apply(c);
    rsp_pending.push_back(p);
    rsp_typed.push_back(want);
    rsp_has_typed.push_back(typed);
  endtask

  // response checker
  always @(posedge clk) begin
    heap_rsp_t got, exp;
    if (!rst && response.valid && response.ready) begin
      got = {response.status, response.read_data, response.element_count,
             response.top_value};
      if (rsp_pending.size() == 0) begin
        $display("%0t: unexpected response %p", $time, got);
        mismatches++;
      end else begin
        exp = rsp_pending.pop_front();
        if (rsp_has_typed.pop_front() && rsp_typed[0] != exp) begin
          $display("%0t: table row disagrees, expected %p predicted %p",
                   $time, rsp_typed[0], exp);
          mismatches++;
        end
        void'(rsp_typed.pop_front());
        if (got.status != exp.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
          mismatches++;
        end
        if (got.read_data != exp.read_data) begin
          $display("%0t: read_data expected %h got %h", $time, exp.read_data,
                   got.read_data);
          mismatches++;
        end
        if (got.element_count != exp.element_count) begin
          $display("%0t: element_count expected %0d got %0d", $time,
                   exp.element_count, got.element_count);
          mismatches++;
        end
        if (got.top_value != exp.top_value) begin
          $display("%0t: top_value expected %h got %h", $time, exp.top_value,
                   got.top_value);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off
  always @(posedge clk) begin
    if (rst) response.ready <= 1'b1;
    else if (hold_rx) response.ready <= 1'b0;
    else if (quiet_rx) response.ready <= 1'b1;
    else response.ready <= ($urandom_range(0, 99) >= 11);
  end

  initial begin
    hold_rx = 1'b0;
    quiet_rx = 1'b0;
    wait (rst == 1'b0);
    repeat (3000) @(posedge clk);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  // directed table: opcode, key, index, typed?, expected
  localparam int NDIR = 22;
  heap_cmd_t dir_cmd  [NDIR];
  bit        dir_tick [NDIR];
  heap_rsp_t dir_rsp  [NDIR];

  initial begin
    heap_cmd_t c;
    int unsigned n_sent;
    dir_cmd = '{
      '{OP_READ,   32'h0,        8'd0},    // read on empty
      '{OP_REMOVE, 32'h5,        8'd0},    // remove on empty
      '{OP_INSERT, 32'h7fffffff, 8'hff},
      '{OP_INSERT, 32'h80000000, 8'h00},
      '{OP_INSERT, 32'h7fffffff, 8'd0},    // duplicate
      '{OP_INSERT, 32'h0,        8'd0},
      '{OP_INSERT, 32'hffffffff, 8'd0},
      '{OP_INSERT, 32'h00000001, 8'd0},
      '{OP_READ,   32'hffffffff, 8'd0},
      '{OP_READ,   32'h0,        8'd4},
      '{OP_READ,   32'h0,        8'd5},    // just past the end
      '{OP_READ,   32'h0,        8'hff},
      '{OP_REMOVE, 32'h12345678, 8'd0},    // absent
      '{OP_REMOVE, 32'h7fffffff, 8'd0},    // remove the root
      '{OP_READ,   32'h0,        8'd0},
      '{OP_REMOVE, 32'h80000000, 8'd0},
      '{OP_INSERT, 32'haaaaaaaa, 8'haa},
      '{OP_INSERT, 32'h55555555, 8'h55},
      '{OP_READ,   32'h0,        8'd1},
      '{OP_CLEAR,  32'hffffffff, 8'hff},
      '{OP_CLEAR,  32'h0,        8'd0},    // clear on empty
      '{OP_READ,   32'h0,        8'd0}
    };
    dir_tick = '{1, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0,
                 0, 1, 1};
    dir_rsp = '{
      '{ST_RANGE,   32'h0, 9'd0, 32'h0},
      '{ST_MISSING, 32'h0, 9'd0, 32'h0},
      '{ST_OK,      32'h0, 9'd1, 32'h7fffffff},
      '0,
      '{ST_DUP,     32'h0, 9'd2, 32'h7fffffff},
      '0, '0, '0, '0, '0, '0,
      '{ST_RANGE,   32'h0, 9'd5, 32'h7fffffff},
      '0, '0, '0, '0, '0, '0, '0, '0,
      '{ST_OK,      32'h0, 9'd0, 32'h0},
      '{ST_RANGE,   32'h0, 9'd0, 32'h0}
    };
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'h7fffffff;
    key_pool[2] = 32'h80000000;
    key_pool[3] = 32'hffffffff;
    heap_fill = 0;
    mismatches = 0;
    quiet_rx = 1'b0;
    request.valid      <= 1'b0;
    request.opcode     <= OP_READ;
    request.key_value  <= '0;
    request.read_index <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NDIR; i++) send_cmd(dir_cmd[i], 1'b1, dir_tick[i], dir_rsp[i]);

    // fill to capacity with distinct values, then overflow
    for (int i = 0; i < CAPACITY; i++) begin
      c = '{OP_INSERT, i * 32'h01000193 - 32'h40000000, 8'($urandom)};
      send_cmd(c, 1'b0);
    end
    send_cmd('{OP_INSERT, 32'h7ffffff0, 8'd0}, 1'b0);   // full
    send_cmd('{OP_INSERT, 32'hc0000000, 8'd0}, 1'b0);   // duplicate when full
    send_cmd('{OP_READ, 32'h0, 8'hff}, 1'b0);
    send_cmd('{OP_REMOVE, heap_img[0], 8'd0}, 1'b0);
    send_cmd('{OP_CLEAR, 32'h0, 8'd0}, 1'b0);
    n_sent = NDIR + CAPACITY + 5;

    // random mix; a stretch with no idling in the middle
    while (n_sent < 1170) begin
      quiet_rx = (n_sent >= 600 && n_sent < 700);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8:
          c = '{OP_INSERT, pick_key(), 8'($urandom)};
        9, 10, 11, 12:
          c = '{OP_REMOVE, pick_key(), 8'($urandom)};
        13:
          c = '{($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_READ, $urandom,
                8'($urandom)};
        default:
          c = '{OP_READ, $urandom,
                8'(heap_fill > 0 && $urandom_range(0, 3) != 0 ?
                   $urandom_range(0, heap_fill - 1) : $urandom)};
      endcase
      send_cmd(c, !quiet_rx);
      n_sent++;
    end
    quiet_rx = 1'b0;
    request.valid <= 1'b0;

    while (rsp_pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(12 * 40000000);
    $display("== FAIL ==");
    $finish;
  end
endmodule
